// File: rtl/bpm_pkg.sv
`timescale 1ns / 1ps
// bpm_pkg: shared types, constants and helper functions for the busy percentage monitor.
// No dependencies; compiled first.
package bpm_pkg;

	// configuration reset value: ticks per measurement period
	localparam logic [7:0] TICKS_RESET = 8'd18;

	// quotient bits of the percentage divide (percent never exceeds 100 < 128)
	localparam int PCT_BITS  = 7;
	localparam int DIV_STEPS = PCT_BITS;
	localparam int STEP_BITS = $clog2(DIV_STEPS);

	localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

	// item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CALL = 1'b1;

	// exempt service-call codes: keyboard/console functions and get time
	localparam logic [7:0] CODE_CHAR_IN      = 8'h01;
	localparam logic [7:0] CODE_DIRECT_IO    = 8'h06;
	localparam logic [7:0] CODE_RAW_IN       = 8'h07;
	localparam logic [7:0] CODE_IN_NO_ECHO   = 8'h08;
	localparam logic [7:0] CODE_BUF_IN       = 8'h0A;
	localparam logic [7:0] CODE_IN_STATUS    = 8'h0B;
	localparam logic [7:0] CODE_FLUSH_IN     = 8'h0C;
	localparam logic [7:0] CODE_GET_TIME     = 8'h2C;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_FINISH
	} bpm_state_t;

	// controller -> datapath
	typedef struct packed {
		logic                 take;     // input word accepted this cycle
		logic                 load;     // load dividend and clear quotient
		logic                 step;     // one restoring divide step
		logic [STEP_BITS-1:0] shift;    // quotient bit of this step
		logic                 publish;  // move result into output register
	} bpm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic period_end;  // the offered word is a tick that closes the period
		logic out_free;    // output register can take a new word
	} bpm_status_t;

	function automatic logic code_is_exempt(input logic [7:0] code);
		logic ex;
		ex = 1'b0;
		case (code)
			CODE_CHAR_IN, CODE_DIRECT_IO, CODE_RAW_IN, CODE_IN_NO_ECHO,
			CODE_BUF_IN, CODE_IN_STATUS, CODE_FLUSH_IN, CODE_GET_TIME: ex = 1'b1;
			default: ex = 1'b0;
		endcase
		return ex;
	endfunction

	// tens digit of (percent mod 100), percent in 0..100
	function automatic logic [3:0] shown_tens_of(input logic [PCT_BITS-1:0] pct);
		logic [PCT_BITS-1:0] shown;
		logic [3:0]          tens;
		shown = (pct >= PCT_FULL) ? '0 : pct;
		tens  = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (shown >= PCT_BITS'(10 * i))
				tens = 4'(i);
		end
		return tens;
	endfunction

	// units digit of (percent mod 100)
	function automatic logic [3:0] shown_units_of(input logic [PCT_BITS-1:0] pct);
		logic [PCT_BITS-1:0] shown;
		logic [PCT_BITS-1:0] tens10;
		logic [PCT_BITS-1:0] units;
		shown  = (pct >= PCT_FULL) ? '0 : pct;
		tens10 = PCT_BITS'(shown_tens_of(pct)) * PCT_BITS'(10);
		units  = shown - tens10;
		return units[3:0];
	endfunction

endpackage

// File: rtl/bpm_if.sv
`timescale 1ns / 1ps
// bpm_in_if / bpm_out_if: valid/ready channels for input and result words.
// No dependencies.
interface bpm_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] call_code;

	modport source (output valid, output func, output call_code, input ready);
	modport sink   (input valid, input func, input call_code, output ready);
endinterface

interface bpm_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] percent_busy;
	logic [3:0] shown_tens;
	logic [3:0] shown_units;
	logic       busy_now;

	modport source (output valid, output percent_busy, output shown_tens,
	                output shown_units, output busy_now, input ready);
	modport sink   (input valid, input percent_busy, input shown_tens,
	                input shown_units, input busy_now, output ready);
endinterface

// File: rtl/busy_percentage_monitor.sv
`timescale 1ns / 1ps
// busy_percentage_monitor: top level, joins controller and datapath.
// Depends on bpm_pkg, bpm_if, bpm_ctrl and bpm_dp.
//
// Usage:
//   in_ch carries one word per observed event: func 0 is a timer tick,
//   func 1 a service call with its code in call_code. A non-exempt call
//   marks the current period busy. After ticks_per_period ticks (one tick if 0) the period
//   closes and one result word leaves on out_ch: percent_busy, its two
//   shown digits (of percent mod 100) and busy_now for the closed period.
//   cfg_we/cfg_wdata write ticks_per_period (reset value 18).
// Timing:
//   Calls and ticks that do not close a period are accepted without a stall.
//   A period-closing tick holds in_ch.ready low through ST_LOAD (forms
//   100*busy), seven restoring divide steps in ST_DIV (one quotient bit
//   per step) and ST_FINISH, which loads the output register once out_ch
//   can take it; out_ch.valid rises when that load is registered.
// Reset and stall:
//   arst_n clears counters, flag and prescaler and drops out_ch.valid.
//   While a result waits on out_ch, new words are still accepted; only a
//   further period close waits in its final cycle until out_ch frees.
module busy_percentage_monitor #(
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	bpm_in_if.sink      in_ch,
	bpm_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);
	import bpm_pkg::*;

	bpm_cmd_t    cmd;
	bpm_status_t status;
	logic        in_ready;

	bpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bpm_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.func         (in_ch.func),
		.call_code    (in_ch.call_code),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.percent_busy (out_ch.percent_busy),
		.shown_tens   (out_ch.shown_tens),
		.shown_units  (out_ch.shown_units),
		.busy_now     (out_ch.busy_now)
	);

	assign in_ch.ready = in_ready;

	// percentage never exceeds full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.percent_busy <= PCT_FULL))
		else $error("percent_busy above 100");

	// shown digits agree with the percentage
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> ((out_ch.percent_busy == PCT_FULL) ?
			(out_ch.shown_tens == 4'd0 && out_ch.shown_units == 4'd0) :
			(PCT_BITS'(out_ch.shown_tens) * PCT_BITS'(10)
				+ PCT_BITS'(out_ch.shown_units) == out_ch.percent_busy)))
		else $error("shown digits do not match percent_busy");

	// a period close is never accepted while the divider is running
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !in_ch.ready)
		else $error("input accepted during divide");

endmodule

// File: rtl/bpm_ctrl.sv
`timescale 1ns / 1ps
// bpm_ctrl: sequencer for the period-end divide and result hand-off.
// Depends on bpm_pkg.
module bpm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bpm_pkg::bpm_status_t  status,
	output bpm_pkg::bpm_cmd_t     cmd
);
	import bpm_pkg::*;

	bpm_state_t           state_q, state_d;
	logic [STEP_BITS-1:0] step_q, step_d;

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.shift   = step_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && status.period_end)
					state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				step_d   = STEP_BITS'(DIV_STEPS - 1);
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (step_q == '0)
					state_d = ST_FINISH;
				else
					step_d = step_q - 1'b1;
			end
			ST_FINISH: begin
				// wait for the output register to free up
				if (status.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/bpm_dp.sv
`timescale 1ns / 1ps
// bpm_dp: counters, busy flag, restoring divider and output register.
// Depends on bpm_pkg; driven by bpm_ctrl commands.
module bpm_dp #(
	parameter int COUNT_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [7:0]                 cfg_wdata,
	input  logic                       func,
	input  logic [7:0]                 call_code,
	input  bpm_pkg::bpm_cmd_t          cmd,
	output bpm_pkg::bpm_status_t       status,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bpm_pkg::PCT_BITS-1:0] percent_busy,
	output logic [3:0]                 shown_tens,
	output logic [3:0]                 shown_units,
	output logic                       busy_now
);
	import bpm_pkg::*;

	localparam int REM_BITS = COUNT_BITS + PCT_BITS;

	logic [7:0]            ticks_per_period_q;
	logic [7:0]            tick_count_q;
	logic [COUNT_BITS-1:0] busy_periods_q;
	logic [COUNT_BITS-1:0] total_periods_q;
	logic                  busy_flag_q;
	logic                  last_busy_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [PCT_BITS-1:0]   quot_q;
	logic                  out_valid_q;
	logic [PCT_BITS-1:0]   pct_out_q;
	logic [3:0]            tens_out_q;
	logic [3:0]            units_out_q;
	logic                  busy_out_q;

	logic [8:0]            tick_next;
	logic                  period_end;
	logic [REM_BITS-1:0]   busy_ext;
	logic [REM_BITS-1:0]   product;
	logic [REM_BITS-1:0]   trial;

	// period end test on the offered word
	assign tick_next  = {1'b0, tick_count_q} + 9'd1;
	assign period_end = (func == KIND_TICK) && (tick_next >= {1'b0, ticks_per_period_q});

	assign status.period_end = period_end;
	assign status.out_free   = !out_valid_q || out_ready;

	// 100 * busy as shift-and-add
	assign busy_ext = {{PCT_BITS{1'b0}}, busy_periods_q};
	assign product  = (busy_ext << 6) + (busy_ext << 5) + (busy_ext << 2);

	// divisor aligned to the current quotient bit
	assign trial = {{PCT_BITS{1'b0}}, total_periods_q} << cmd.shift;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ticks_per_period_q <= TICKS_RESET;
		else if (cfg_we)
			ticks_per_period_q <= cfg_wdata;
	end

	// prescaler, flag and saturating period counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q    <= '0;
			busy_periods_q  <= '0;
			total_periods_q <= '0;
			busy_flag_q     <= 1'b0;
			last_busy_q     <= 1'b0;
		end else if (cmd.take) begin
			if (func == KIND_CALL) begin
				if (!code_is_exempt(call_code))
					busy_flag_q <= 1'b1;
			end else if (!period_end) begin
				tick_count_q <= tick_next[7:0];
			end else begin
				tick_count_q <= '0;
				busy_flag_q  <= 1'b0;
				last_busy_q  <= busy_flag_q;
				if (busy_flag_q && (busy_periods_q != '1))
					busy_periods_q <= busy_periods_q + 1'b1;
				if (total_periods_q != '1)
					total_periods_q <= total_periods_q + 1'b1;
			end
		end
	end

	// restoring divide, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= product;
			quot_q <= '0;
		end else if (cmd.step) begin
			if (rem_q >= trial) begin
				rem_q              <= rem_q - trial;
				quot_q[cmd.shift]  <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.publish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			pct_out_q   <= quot_q;
			tens_out_q  <= shown_tens_of(quot_q);
			units_out_q <= shown_units_of(quot_q);
			busy_out_q  <= last_busy_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign percent_busy = pct_out_q;
	assign shown_tens   = tens_out_q;
	assign shown_units  = units_out_q;
	assign busy_now     = busy_out_q;

endmodule

// File: tb/bpm_checker.sv
`timescale 1ns / 1ps
// bpm_checker: watches the input and result channels of the busy percentage monitor,
// tracks the utilization counters itself and compares every result word field by field.
// Depends on bpm_pkg and bpm_if.
module bpm_checker #(
	parameter int COUNT_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	bpm_in_if          in_mon,
	bpm_out_if         out_mon,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output int         mismatch_count,
	output int         reports_due
);
	import bpm_pkg::*;

	typedef struct packed {
		logic [6:0] percent;
		logic [3:0] tens;
		logic [3:0] units;
		logic       busy;
	} util_report_t;

	localparam logic [63:0] COUNT_LIMIT = (64'd1 << COUNT_BITS) - 64'd1;

	logic [7:0]   period_len;
	logic [7:0]   tick_cnt;
	logic [63:0]  busy_cnt;
	logic [63:0]  total_cnt;
	logic         period_busy;
	util_report_t expected_reports[$];

	// saturating period counter
	function automatic logic [63:0] bump(input logic [63:0] v);
		return (v >= COUNT_LIMIT) ? COUNT_LIMIT : v + 64'd1;
	endfunction

	// advance the utilization state by one accepted word; queue a report at period end
	task automatic predict_utilization(input logic func, input logic [7:0] code);
		logic [8:0]   next_cnt;
		logic [63:0]  pct;
		logic [6:0]   shown;
		util_report_t rep;
		if (func == KIND_CALL) begin
			if (!(code inside {CODE_CHAR_IN, CODE_DIRECT_IO, CODE_RAW_IN, CODE_IN_NO_ECHO,
			                   CODE_BUF_IN, CODE_IN_STATUS, CODE_FLUSH_IN, CODE_GET_TIME}))
				period_busy = 1'b1;
		end else begin
			next_cnt = {1'b0, tick_cnt} + 9'd1;
			if (next_cnt < {1'b0, period_len}) begin
				tick_cnt = next_cnt[7:0];
			end else begin
				if (period_busy)
					busy_cnt = bump(busy_cnt);
				total_cnt = bump(total_cnt);
				pct = (busy_cnt * 64'd100) / total_cnt;
				if (pct > 64'd100)
					pct = 64'd100;
				// a full 100 shows as two zero digits
				shown = 7'(pct % 64'd100);
				rep.percent = pct[6:0];
				rep.tens    = 4'(shown / 7'd10);
				rep.units   = 4'(shown % 7'd10);
				rep.busy    = period_busy;
				expected_reports.push_back(rep);
				period_busy = 1'b0;
				tick_cnt    = 8'd0;
			end
		end
	endtask

	// compare one result word with the oldest expected report
	task automatic check_report();
		util_report_t exp_rep;
		if (expected_reports.size() == 0) begin
			$error("result word with no report expected: percent_busy %0d",
			       out_mon.percent_busy);
			mismatch_count++;
		end else begin
			exp_rep = expected_reports.pop_front();
			if (out_mon.percent_busy !== exp_rep.percent) begin
				$error("percent_busy: expected %0d, got %0d", exp_rep.percent,
				       out_mon.percent_busy);
				mismatch_count++;
			end
			if (out_mon.shown_tens !== exp_rep.tens) begin
				$error("shown_tens: expected %0d, got %0d", exp_rep.tens, out_mon.shown_tens);
				mismatch_count++;
			end
			if (out_mon.shown_units !== exp_rep.units) begin
				$error("shown_units: expected %0d, got %0d", exp_rep.units,
				       out_mon.shown_units);
				mismatch_count++;
			end
			if (out_mon.busy_now !== exp_rep.busy) begin
				$error("busy_now: expected %0d, got %0d", exp_rep.busy, out_mon.busy_now);
				mismatch_count++;
			end
		end
	endtask

	// sample both channels and the config port at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_len     = TICKS_RESET;
			tick_cnt       = 8'd0;
			busy_cnt       = 64'd0;
			total_cnt      = 64'd0;
			period_busy    = 1'b0;
			mismatch_count = 0;
			expected_reports.delete();
			reports_due    = 0;
		end else begin
			if (out_mon.valid && out_mon.ready)
				check_report();
			if (in_mon.valid && in_mon.ready)
				predict_utilization(in_mon.func, in_mon.call_code);
			if (cfg_we)
				period_len = cfg_wdata;
			reports_due = expected_reports.size();
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: drives the busy percentage monitor with directed and random words,
// writes the period register between phases and reports the verdict.
// Depends on bpm_pkg, bpm_if, bpm_checker and the RTL.
module testbench;
	import bpm_pkg::*;

	localparam int COUNT_BITS    = 32;
	localparam int WORD_TARGET   = 1950;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	int         mismatch_count;
	int         reports_due;
	int         words_sent;
	int         reports_taken;

	bpm_in_if  in_ch();
	bpm_out_if out_ch();

	busy_percentage_monitor #(.COUNT_BITS(COUNT_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	bpm_checker #(.COUNT_BITS(COUNT_BITS)) monitor_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_mon        (in_ch),
		.out_mon       (out_ch),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mismatch_count(mismatch_count),
		.reports_due   (reports_due)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] exempt_code(input int idx);
		case (idx)
			0:       return CODE_CHAR_IN;
			1:       return CODE_DIRECT_IO;
			2:       return CODE_RAW_IN;
			3:       return CODE_IN_NO_ECHO;
			4:       return CODE_BUF_IN;
			5:       return CODE_IN_STATUS;
			6:       return CODE_FLUSH_IN;
			default: return CODE_GET_TIME;
		endcase
	endfunction

	// offer one word after a random gap; returns at the falling edge after acceptance
	task automatic offer_word(input logic func, input logic [7:0] code);
		int gap;
		gap = (words_sent % 200 < 40) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.func      <= func;
		in_ch.call_code <= code;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		@(negedge clk);
		words_sent++;
	endtask

	task automatic call_then_tick(input logic [7:0] code);
		offer_word(KIND_CALL, code);
		offer_word(KIND_TICK, 8'h00);
	endtask

	// stop offering, wait out all reports and the divide pipeline
	task automatic settle_idle();
		in_ch.valid <= 1'b0;
		while (reports_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_period(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// one random phase at a fixed period
	task automatic run_phase(input logic [7:0] period, input int count, input int call_pct);
		logic [7:0] code;
		write_period(period);
		repeat (count) begin
			if ($urandom_range(0, 99) < call_pct) begin
				if ($urandom_range(0, 1) == 1)
					code = exempt_code($urandom_range(0, 7));
				else
					code = 8'($urandom_range(0, 255));
				offer_word(KIND_CALL, code);
			end else begin
				offer_word(KIND_TICK, 8'($urandom_range(0, 255)));
			end
		end
		settle_idle();
	endtask

	// stimulus and verdict
	initial begin
		int sel;
		logic [7:0] period;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = 8'd0;
		in_ch.valid     = 1'b0;
		in_ch.func      = KIND_TICK;
		in_ch.call_code = 8'd0;
		words_sent      = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// one tick per period: full percentage first, then each exempt code
		write_period(8'd1);
		call_then_tick(8'h00);
		offer_word(KIND_TICK, 8'hFF);
		call_then_tick(CODE_CHAR_IN);
		for (int i = 0; i < 8; i++)
			offer_word(KIND_CALL, exempt_code(i));
		offer_word(KIND_TICK, 8'h55);
		call_then_tick(8'hFF);
		settle_idle();

		// zero period: every tick closes a period
		write_period(8'd0);
		offer_word(KIND_TICK, 8'hAA);
		offer_word(KIND_TICK, 8'h00);
		settle_idle();

		// period lowered below the running count
		write_period(8'd10);
		repeat (5) offer_word(KIND_TICK, 8'h00);
		settle_idle();
		write_period(8'd3);
		offer_word(KIND_TICK, 8'h00);
		settle_idle();

		// longest period, then mostly short ones
		run_phase(8'd255, 300, 8);
		while (words_sent < WORD_TARGET) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				period = 8'd0;
			else if (sel == 1)
				period = 8'($urandom_range(7, 40));
			else
				period = 8'($urandom_range(1, 6));
			run_phase(period, $urandom_range(80, 200), $urandom_range(0, 60));
		end

		if (mismatch_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// result receiver: random ready gaps, bursts of none, and two long hold-offs
	initial begin
		int gap;
		out_ch.ready  = 1'b0;
		reports_taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (reports_taken == 40 || reports_taken == 180)
				gap = HOLD_CYCLES;
			else if (reports_taken % 50 < 10)
				gap = 0;
			else
				gap = $urandom_range(0, 5);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
			@(negedge clk);
			reports_taken++;
		end
	end

	// hang guard
	initial begin
		#(5_000_000);
		$display("testbench: errors");
		$finish;
	end

endmodule

// File: filelist.f
rtl/bpm_pkg.sv
rtl/bpm_if.sv
rtl/bpm_ctrl.sv
rtl/bpm_dp.sv
rtl/busy_percentage_monitor.sv
tb/bpm_checker.sv
tb/testbench.sv
